### hw/rtl/tsc_pkg.sv
// Shared types and constants of the Tchebycheff scalarized comparator.
package tsc_pkg;

    // Stream payload layout
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;
    localparam int VALUE_W     = 32;
    localparam int WEIGHT_W    = 16;
    localparam int SLOT_W      = 2;
    localparam int SCORE_W     = 32;
    localparam int CODE_W      = 2;

    // Quotient bits the divider produces; larger quotients saturate
    localparam int QUO_W       = 32;
    localparam int CNT_W       = 5;
    localparam logic [CNT_W-1:0] CNT_LAST_STEP = CNT_W'(QUO_W - 1);

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Item kinds carried in tuser
    localparam logic MODE_FRAME   = 1'b0;
    localparam logic MODE_COMPARE = 1'b1;

    // Register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SHARE_FIRST_WEIGHTS = '0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAME_MM,
        ST_FRAME_SPAN,
        ST_CMP_PREP,
        ST_CMP_MUL,
        ST_CMP_DINIT,
        ST_CMP_DIV,
        ST_CMP_UPD,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic frame_mm;
        logic frame_span;
        logic cmp_prep;
        logic cmp_mul;
        logic div_init;
        logic div_step;
        logic cmp_upd;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

### hw/rtl/tsc_ctrl.sv
// Sequencer that steps one item at a time through the datapath.
module tsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    input  tsc_pkg::t_status i_status,
    output logic             o_in_ready,
    output tsc_pkg::t_cmd    o_cmd
);

    tsc_pkg::t_state r_state;
    tsc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_mode == tsc_pkg::MODE_COMPARE) ?
                              tsc_pkg::ST_CMP_PREP : tsc_pkg::ST_FRAME_MM;
                end
            end
            tsc_pkg::ST_FRAME_MM:   n_state = tsc_pkg::ST_FRAME_SPAN;
            tsc_pkg::ST_FRAME_SPAN: n_state = tsc_pkg::ST_IDLE;
            tsc_pkg::ST_CMP_PREP:   n_state = tsc_pkg::ST_CMP_MUL;
            tsc_pkg::ST_CMP_MUL:    n_state = tsc_pkg::ST_CMP_DINIT;
            tsc_pkg::ST_CMP_DINIT:  n_state = tsc_pkg::ST_CMP_DIV;
            tsc_pkg::ST_CMP_DIV: begin
                if (i_status.div_last) begin
                    n_state = tsc_pkg::ST_CMP_UPD;
                end
            end
            tsc_pkg::ST_CMP_UPD: begin
                n_state = i_status.item_last ? tsc_pkg::ST_EMIT : tsc_pkg::ST_IDLE;
            end
            tsc_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = tsc_pkg::ST_IDLE;
                end
            end
            default: n_state = tsc_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tsc_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            tsc_pkg::ST_FRAME_MM:   o_cmd.frame_mm   = 1'b1;
            tsc_pkg::ST_FRAME_SPAN: o_cmd.frame_span = 1'b1;
            tsc_pkg::ST_CMP_PREP:   o_cmd.cmp_prep   = 1'b1;
            tsc_pkg::ST_CMP_MUL:    o_cmd.cmp_mul    = 1'b1;
            tsc_pkg::ST_CMP_DINIT:  o_cmd.div_init   = 1'b1;
            tsc_pkg::ST_CMP_DIV:    o_cmd.div_step   = 1'b1;
            tsc_pkg::ST_CMP_UPD:    o_cmd.cmp_upd    = 1'b1;
            tsc_pkg::ST_EMIT:       o_cmd.emit       = i_status.out_free;
            default: ;
        endcase
    end

endmodule

### hw/rtl/tsc_dp.sv
// Datapath: slot range store, two scoring lanes with serial dividers, result register.
module tsc_dp #(
    parameter int SLOT_COUNT = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsc_pkg::t_cmd                     i_cmd,
    output tsc_pkg::t_status                  o_status,
    input  logic                              i_share_first_weights,
    input  logic                              i_new_frame,
    input  logic [tsc_pkg::SLOT_W-1:0]        i_slot,
    input  logic signed [tsc_pkg::VALUE_W-1:0] i_value_a,
    input  logic                              i_present_a,
    input  logic signed [tsc_pkg::VALUE_W-1:0] i_value_b,
    input  logic                              i_present_b,
    input  logic [tsc_pkg::WEIGHT_W-1:0]      i_weight_a,
    input  logic [tsc_pkg::WEIGHT_W-1:0]      i_weight_b,
    input  logic                              i_last,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [tsc_pkg::CODE_W-1:0]        o_order_code,
    output logic [tsc_pkg::SCORE_W-1:0]       o_score_a,
    output logic [tsc_pkg::SCORE_W-1:0]       o_score_b,
    output logic                              o_infinite_a,
    output logic                              o_infinite_b
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    // weight * 16 * diff
    localparam int MW = VALUE_BITS + tsc_pkg::WEIGHT_W;
    localparam int PW = MW + 4;
    localparam logic signed [VALUE_BITS-1:0] MIN_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] MAX_RESET = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Captured item
    logic                               r_new_frame;
    logic [tsc_pkg::SLOT_W-1:0]         r_slot;
    logic signed [VALUE_BITS-1:0]       r_va;
    logic signed [VALUE_BITS-1:0]       r_vb;
    logic                               r_pa;
    logic                               r_pb;
    logic [tsc_pkg::WEIGHT_W-1:0]       r_wa;
    logic [tsc_pkg::WEIGHT_W-1:0]       r_wb;
    logic                               r_last;

    // Slot range store
    logic signed [VALUE_BITS-1:0]       r_min  [SLOT_COUNT];
    logic signed [VALUE_BITS-1:0]       r_max  [SLOT_COUNT];
    logic [VALUE_BITS-1:0]              r_span [SLOT_COUNT];

    // Scoring lanes
    logic [VALUE_BITS-1:0]              r_diff_a, r_diff_b;
    logic [tsc_pkg::WEIGHT_W-1:0]       r_wt_a, r_wt_b;
    logic                               r_zero_a, r_zero_b;
    logic [VALUE_BITS-1:0]              r_div_span;
    logic [PW-1:0]                      r_prod_a, r_prod_b;
    logic [VALUE_BITS-1:0]              r_rem_a, r_rem_b;
    logic [tsc_pkg::QUO_W-1:0]          r_low_a, r_low_b;
    logic                               r_sat_a, r_sat_b;
    logic [tsc_pkg::CNT_W-1:0]          r_cnt;

    // Running scores
    logic [tsc_pkg::SCORE_W-1:0]        r_run_a, r_run_b;
    logic                               r_uns_a, r_uns_b;

    // Result register
    logic                               r_out_valid;
    logic [tsc_pkg::CODE_W-1:0]         r_order_code;
    logic [tsc_pkg::SCORE_W-1:0]        r_score_a, r_score_b;
    logic                               r_inf_a, r_inf_b;

    logic                               w_slot_ok;
    logic [IW-1:0]                      w_idx;
    logic signed [VALUE_BITS-1:0]       w_cur_min, w_cur_max;
    logic [VALUE_BITS-1:0]              w_cur_span;
    logic signed [VALUE_BITS-1:0]       w_base_min, w_base_max, w_new_min, w_new_max;
    logic [tsc_pkg::WEIGHT_W-1:0]       w_wt_b;
    logic [MW-1:0]                      w_mul_a, w_mul_b;
    logic [VALUE_BITS-1:0]              w_hi_a, w_hi_b;
    logic [VALUE_BITS:0]                w_rem2_a, w_rem2_b, w_span_x;
    logic                               w_ge_a, w_ge_b;
    logic [tsc_pkg::SCORE_W-1:0]        w_term_a, w_term_b;
    logic [tsc_pkg::SCORE_W-1:0]        w_sa, w_sb;
    logic                               w_a_le_b, w_b_le_a;

    // Slot decode; out-of-range slots read entry zero and are masked
    assign w_slot_ok  = (int'(r_slot) < SLOT_COUNT);
    assign w_idx      = w_slot_ok ? IW'(r_slot) : '0;
    assign w_cur_min  = r_min[w_idx];
    assign w_cur_max  = r_max[w_idx];
    assign w_cur_span = r_span[w_idx];

    // Min/max update, from the reset values when a new frame opens
    assign w_base_min = r_new_frame ? MIN_RESET : w_cur_min;
    assign w_base_max = r_new_frame ? MAX_RESET : w_cur_max;
    assign w_new_min  = (r_va < w_base_min) ? r_va : w_base_min;
    assign w_new_max  = (r_va > w_base_max) ? r_va : w_base_max;

    assign w_wt_b  = i_share_first_weights ? r_wa : r_wb;

    // Weight times distance
    assign w_mul_a = MW'(r_diff_a) * MW'(r_wt_a);
    assign w_mul_b = MW'(r_diff_b) * MW'(r_wt_b);

    // Dividend bits above the quotient window
    assign w_hi_a  = VALUE_BITS'(r_prod_a[PW-1:tsc_pkg::QUO_W]);
    assign w_hi_b  = VALUE_BITS'(r_prod_b[PW-1:tsc_pkg::QUO_W]);

    // Restoring division step
    assign w_span_x = {1'b0, r_div_span};
    assign w_rem2_a = {r_rem_a, r_low_a[tsc_pkg::QUO_W-1]};
    assign w_rem2_b = {r_rem_b, r_low_b[tsc_pkg::QUO_W-1]};
    assign w_ge_a   = (w_rem2_a >= w_span_x);
    assign w_ge_b   = (w_rem2_b >= w_span_x);

    // Terms after division
    assign w_term_a = r_zero_a ? '0 : (r_sat_a ? tsc_pkg::SCORE_MAX : r_low_a);
    assign w_term_b = r_zero_b ? '0 : (r_sat_b ? tsc_pkg::SCORE_MAX : r_low_b);

    // Final scores and order; infinite equals infinite and exceeds finite
    assign w_sa     = r_uns_a ? tsc_pkg::SCORE_MAX : r_run_a;
    assign w_sb     = r_uns_b ? tsc_pkg::SCORE_MAX : r_run_b;
    assign w_a_le_b = r_uns_a ? r_uns_b : (r_uns_b || (w_sa <= w_sb));
    assign w_b_le_a = r_uns_b ? r_uns_a : (r_uns_a || (w_sb <= w_sa));

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_new_frame <= i_new_frame;
            r_slot      <= i_slot;
            r_va        <= VALUE_BITS'($unsigned(i_value_a));
            r_vb        <= VALUE_BITS'($unsigned(i_value_b));
            r_pa        <= i_present_a;
            r_pb        <= i_present_b;
            r_wa        <= i_weight_a;
            r_wb        <= i_weight_b;
            r_last      <= i_last;
        end
    end

    // Slot range store; a new frame clears every slot before the sample lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_min[i]  <= MIN_RESET;
                r_max[i]  <= MAX_RESET;
                r_span[i] <= '0;
            end
        end else if (i_cmd.frame_mm) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (r_pa && w_slot_ok && (IW'(i) == w_idx)) begin
                    r_min[i] <= w_new_min;
                    r_max[i] <= w_new_max;
                end else if (r_new_frame) begin
                    r_min[i] <= MIN_RESET;
                    r_max[i] <= MAX_RESET;
                end
                if (r_new_frame) begin
                    r_span[i] <= '0;
                end
            end
        end else if (i_cmd.frame_span && r_pa && w_slot_ok) begin
            r_span[w_idx] <= VALUE_BITS'(w_cur_max - w_cur_min);
        end
    end

    // Lane setup, multiply, divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_prep) begin
            r_diff_a   <= VALUE_BITS'(r_va - w_cur_min);
            r_diff_b   <= VALUE_BITS'(r_vb - w_cur_min);
            r_wt_a     <= r_wa;
            r_wt_b     <= w_wt_b;
            r_div_span <= w_cur_span;
            r_zero_a   <= !(r_pa && w_slot_ok && (w_cur_span != '0) &&
                            (r_va > w_cur_min) && (r_wa != '0));
            r_zero_b   <= !(r_pb && w_slot_ok && (w_cur_span != '0) &&
                            (r_vb > w_cur_min) && (w_wt_b != '0));
        end
        if (i_cmd.cmp_mul) begin
            r_prod_a <= {w_mul_a, 4'b0000};
            r_prod_b <= {w_mul_b, 4'b0000};
        end
        if (i_cmd.div_init) begin
            r_rem_a <= w_hi_a;
            r_rem_b <= w_hi_b;
            r_low_a <= r_prod_a[tsc_pkg::QUO_W-1:0];
            r_low_b <= r_prod_b[tsc_pkg::QUO_W-1:0];
            r_sat_a <= (w_hi_a >= r_div_span);
            r_sat_b <= (w_hi_b >= r_div_span);
            r_cnt   <= tsc_pkg::CNT_LAST_STEP;
        end else if (i_cmd.div_step) begin
            // Shift dividend bits out and quotient bits in
            r_rem_a <= w_ge_a ? VALUE_BITS'(w_rem2_a - w_span_x) : VALUE_BITS'(w_rem2_a);
            r_rem_b <= w_ge_b ? VALUE_BITS'(w_rem2_b - w_span_x) : VALUE_BITS'(w_rem2_b);
            r_low_a <= {r_low_a[tsc_pkg::QUO_W-2:0], w_ge_a};
            r_low_b <= {r_low_b[tsc_pkg::QUO_W-2:0], w_ge_b};
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    // Running maxima and absence flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_a <= '0;
            r_run_b <= '0;
            r_uns_a <= 1'b0;
            r_uns_b <= 1'b0;
        end else if (i_cmd.cmp_upd) begin
            if (w_term_a > r_run_a) begin
                r_run_a <= w_term_a;
            end
            if (w_term_b > r_run_b) begin
                r_run_b <= w_term_b;
            end
            r_uns_a <= r_uns_a | !r_pa;
            r_uns_b <= r_uns_b | !r_pb;
        end else if (i_cmd.emit) begin
            r_run_a <= '0;
            r_run_b <= '0;
            r_uns_a <= 1'b0;
            r_uns_b <= 1'b0;
        end
    end

    // Result register, held until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_order_code <= {w_b_le_a, w_a_le_b};
            r_score_a    <= w_sa;
            r_score_b    <= w_sb;
            r_inf_a      <= r_uns_a;
            r_inf_b      <= r_uns_b;
        end
    end

    assign o_status.item_last = r_last;
    assign o_status.div_last  = (r_cnt == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_order_code = r_order_code;
    assign o_score_a    = r_score_a;
    assign o_score_b    = r_score_b;
    assign o_infinite_a = r_inf_a;
    assign o_infinite_b = r_inf_b;

endmodule

### hw/rtl/tchebycheff_scalarized_compare_top.sv
// Top level: stream and register ports around the sequencer and datapath.
// Items are taken one at a time; a frame item passes the min/max and span states,
// a compare item the prepare, multiply, divider-init, 32-step divide and update
// states, then emit with tlast, plus any wait for a held result to go. The result
// is registered and held until taken; the next item is taken meanwhile.
// Reset (synchronous, active low) clears slot store, scores, register, result valid.
module tchebycheff_scalarized_compare_top #(
    parameter int SLOT_COUNT = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // new_frame, slot, value_a, present_a, value_b, present_b, weight_a,
    // weight_b, zero pad
    input  logic [tsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    // mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // order_code, score_a, score_b, infinite_a, infinite_b, zero pad
    output logic [tsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsc_pkg::ADDR_W-1:0]         paddr,
    input  logic [tsc_pkg::DATA_W-1:0]         pwdata,
    output logic [tsc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic             r_share_first_weights;
    logic             w_sel_share;
    tsc_pkg::t_cmd    w_cmd;
    tsc_pkg::t_status w_status;
    logic [tsc_pkg::CODE_W-1:0]  w_order_code;
    logic [tsc_pkg::SCORE_W-1:0] w_score_a;
    logic [tsc_pkg::SCORE_W-1:0] w_score_b;
    logic             w_inf_a;
    logic             w_inf_b;

    // Register decode
    assign pready      = 1'b1;
    assign w_sel_share = (paddr[tsc_pkg::ADDR_W-1:2] == tsc_pkg::REG_SHARE_FIRST_WEIGHTS);
    assign prdata      = w_sel_share ? tsc_pkg::DATA_W'(r_share_first_weights) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share_first_weights <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_sel_share) begin
            r_share_first_weights <= pwdata[0];
        end
    end

    tsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tsc_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_share_first_weights (r_share_first_weights),
        .i_new_frame           (s_axis_tdata[0]),
        .i_slot                (s_axis_tdata[2:1]),
        .i_value_a             (s_axis_tdata[34:3]),
        .i_present_a           (s_axis_tdata[35]),
        .i_value_b             (s_axis_tdata[67:36]),
        .i_present_b           (s_axis_tdata[68]),
        .i_weight_a            (s_axis_tdata[84:69]),
        .i_weight_b            (s_axis_tdata[100:85]),
        .i_last                (s_axis_tlast),
        .i_out_ready           (m_axis_tready),
        .o_out_valid           (m_axis_tvalid),
        .o_order_code          (w_order_code),
        .o_score_a             (w_score_a),
        .o_score_b             (w_score_b),
        .o_infinite_a          (w_inf_a),
        .o_infinite_b          (w_inf_b)
    );

    // Pack the result
    assign m_axis_tdata = {4'b0000, w_inf_b, w_inf_a, w_score_b, w_score_a, w_order_code};

endmodule

### hw/rtl/tsc_checker.sv
// Port-level checks of the comparator, bound to the top level.
module tsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // One item at a time: no transfer in the cycle after one
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Two scores are always ordered one way or the other
    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b00)
        else $error("empty order code");

    // An infinite candidate a reports an all-ones score a
    a_inf_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[66] |-> m_axis_tdata[33:2] == tsc_pkg::SCORE_MAX)
        else $error("infinite score a not saturated");

endmodule

bind tchebycheff_scalarized_compare_top tsc_checker u_tsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_tchebycheff_scalarized_compare_top.sv
// Testbench for the Tchebycheff scalarized comparator: directed and random streams.
`timescale 1ns / 100ps

module tb_tchebycheff_scalarized_compare_top;

    localparam int IN_TDATA_W  = tsc_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = tsc_pkg::OUT_TDATA_W;
    localparam int VALUE_W     = tsc_pkg::VALUE_W;
    localparam int WEIGHT_W    = tsc_pkg::WEIGHT_W;
    localparam int SLOT_W      = tsc_pkg::SLOT_W;
    localparam int SCORE_W     = tsc_pkg::SCORE_W;
    localparam int CODE_W      = tsc_pkg::CODE_W;
    localparam int ADDR_W      = tsc_pkg::ADDR_W;
    localparam int DATA_W      = tsc_pkg::DATA_W;
    localparam logic [SCORE_W-1:0] SCORE_MAX = tsc_pkg::SCORE_MAX;
    localparam logic MODE_FRAME   = tsc_pkg::MODE_FRAME;
    localparam logic MODE_COMPARE = tsc_pkg::MODE_COMPARE;
    localparam logic [ADDR_W-3:0] REG_SHARE_FIRST_WEIGHTS = tsc_pkg::REG_SHARE_FIRST_WEIGHTS;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int RESULT_LATENCY = 37;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 8;
    localparam int HOLD_CYCLES    = 600;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int TARGET_ITEMS   = 1150;
    localparam int NSLOTS         = 4;

    localparam logic signed [VALUE_W-1:0] VALUE_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_BOT = 32'sh8000_0000;

    typedef struct {
        logic                      mode;
        logic                      new_frame;
        logic [SLOT_W-1:0]         slot;
        logic [VALUE_W-1:0]        value_a;
        logic                      present_a;
        logic [VALUE_W-1:0]        value_b;
        logic                      present_b;
        logic [WEIGHT_W-1:0]       weight_a;
        logic [WEIGHT_W-1:0]       weight_b;
        logic                      last;
    } t_objective_item;

    typedef struct {
        logic [CODE_W-1:0]         order_code;
        logic [SCORE_W-1:0]        score_a;
        logic [SCORE_W-1:0]        score_b;
        logic                      infinite_a;
        logic                      infinite_b;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    tchebycheff_scalarized_compare_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: pool range per slot, running scores, register copy
    logic signed [VALUE_W-1:0] pool_min [NSLOTS];
    logic signed [VALUE_W-1:0] pool_max [NSLOTS];
    logic [VALUE_W:0]          pool_span [NSLOTS];
    logic [SCORE_W-1:0]        worst_a;
    logic [SCORE_W-1:0]        worst_b;
    logic                      missing_a;
    logic                      missing_b;
    logic                      share_weights;

    t_verdict predicted_verdicts [$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       cycle_count = 0;

    // Sender burst control and receiver hold-off handshake
    int       burst_left = 0;
    bit       valid_up = 1'b0;
    bit       no_gap = 1'b0;
    bit       hold_request = 1'b0;
    bit       receiver_holding = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_pool_range();
        for (int s = 0; s < NSLOTS; s++) begin
            pool_min[s]  = VALUE_TOP;
            pool_max[s]  = VALUE_BOT;
            pool_span[s] = '0;
        end
    endtask

    // floor(weight * 16 * (value - min) / span), saturated; nothing on a flat slot
    function automatic logic [SCORE_W-1:0] weighted_distance(
        input logic signed [VALUE_W-1:0] value,
        input int                        s,
        input logic [WEIGHT_W-1:0]       weight
    );
        logic [63:0] diff;
        logic [63:0] quot;
        if (pool_span[s] == '0 || value <= pool_min[s] || weight == '0)
            return '0;
        diff = 64'(longint'(value) - longint'(pool_min[s]));
        quot = (diff * {44'd0, weight, 4'd0}) / {31'd0, pool_span[s]};
        return (quot > 64'(SCORE_MAX)) ? SCORE_MAX : quot[SCORE_W-1:0];
    endfunction

    task automatic score_item(input t_objective_item it);
        int                        s;
        logic signed [VALUE_W-1:0] va;
        logic signed [VALUE_W-1:0] vb;
        logic [SCORE_W-1:0]        term;
        t_verdict                  v;
        s  = int'(it.slot);
        va = it.value_a;
        vb = it.value_b;
        if (it.mode == MODE_FRAME) begin
            if (it.new_frame)
                clear_pool_range();
            if (it.present_a) begin
                if (va < pool_min[s]) pool_min[s] = va;
                if (va > pool_max[s]) pool_max[s] = va;
                pool_span[s] = (VALUE_W+1)'(longint'(pool_max[s]) - longint'(pool_min[s]));
            end
            return;
        end
        if (!it.present_a) begin
            missing_a = 1'b1;
        end else begin
            term = weighted_distance(va, s, it.weight_a);
            if (term > worst_a) worst_a = term;
        end
        if (!it.present_b) begin
            missing_b = 1'b1;
        end else begin
            term = weighted_distance(vb, s, share_weights ? it.weight_a : it.weight_b);
            if (term > worst_b) worst_b = term;
        end
        if (!it.last)
            return;
        v.score_a    = missing_a ? SCORE_MAX : worst_a;
        v.score_b    = missing_b ? SCORE_MAX : worst_b;
        v.infinite_a = missing_a;
        v.infinite_b = missing_b;
        // Infinite equals infinite and loses to every finite score
        v.order_code[0] = missing_a ? missing_b : (missing_b || v.score_a <= v.score_b);
        v.order_code[1] = missing_b ? missing_a : (missing_a || v.score_b <= v.score_a);
        predicted_verdicts.insert(predicted_verdicts.size(), v);
        worst_a   = '0;
        worst_b   = '0;
        missing_a = 1'b0;
        missing_b = 1'b0;
    endtask

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_verdicts.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_v = predicted_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== exp_v.order_code) begin
                    $error("order_code mismatch: expected %h, actual %h",
                           exp_v.order_code, m_axis_tdata[1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[33:2] !== exp_v.score_a) begin
                    $error("score_a mismatch: expected %h, actual %h",
                           exp_v.score_a, m_axis_tdata[33:2]);
                    mismatches++;
                end
                if (m_axis_tdata[65:34] !== exp_v.score_b) begin
                    $error("score_b mismatch: expected %h, actual %h",
                           exp_v.score_b, m_axis_tdata[65:34]);
                    mismatches++;
                end
                if (m_axis_tdata[66] !== exp_v.infinite_a) begin
                    $error("infinite_a mismatch: expected %h, actual %h",
                           exp_v.infinite_a, m_axis_tdata[66]);
                    mismatches++;
                end
                if (m_axis_tdata[67] !== exp_v.infinite_b) begin
                    $error("infinite_b mismatch: expected %h, actual %h",
                           exp_v.infinite_b, m_axis_tdata[67]);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Stall in runs of random style; honor a long hold-off when asked
    initial begin : result_sink
        int style;
        int run;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request     = 1'b0;
                receiver_holding = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                receiver_holding = 1'b0;
            end
            style = $urandom_range(0, 3);
            run   = $urandom_range(4, 48);
            for (int k = 0; k < run; k++) begin
                case (style)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_axis_tready <= (k >= run / 2);
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_item(input t_objective_item it);
        int gap;
        if (!valid_up) begin
            gap = no_gap ? 0 : $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tlast  <= it.last;
        s_axis_tdata  <= {3'b000, it.weight_b, it.weight_a, it.present_b, it.value_b,
                          it.present_a, it.value_a, it.slot, it.new_frame};
        valid_up = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        score_item(it);
        items_sent++;
        burst_left--;
        // End the burst; the next item waits out a random gap first
        if (burst_left <= 0 && !no_gap) begin
            s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        if (valid_up) begin
            s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (predicted_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the sharing register, then read it back
    task automatic write_share(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SHARE_FIRST_WEIGHTS, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        share_weights = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== value) begin
            $error("share_first_weights readback mismatch: expected %h, actual %h",
                   value, prdata[0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- item builders

    function automatic t_objective_item frame_sample(
        input logic fresh, input int s, input logic [VALUE_W-1:0] value, input logic present
    );
        t_objective_item it;
        it.mode      = MODE_FRAME;
        it.new_frame = fresh;
        it.slot      = SLOT_W'(s);
        it.value_a   = value;
        it.present_a = present;
        it.value_b   = $urandom();
        it.present_b = 1'($urandom_range(0, 1));
        it.weight_a  = 16'($urandom());
        it.weight_b  = 16'($urandom());
        it.last      = 1'b0;
        return it;
    endfunction

    function automatic t_objective_item compare_element(
        input int s,
        input logic [VALUE_W-1:0] va, input logic pa, input logic [WEIGHT_W-1:0] wa,
        input logic [VALUE_W-1:0] vb, input logic pb, input logic [WEIGHT_W-1:0] wb,
        input logic last
    );
        t_objective_item it;
        it.mode      = MODE_COMPARE;
        it.new_frame = 1'b0;
        it.slot      = SLOT_W'(s);
        it.value_a   = va;
        it.present_a = pa;
        it.value_b   = vb;
        it.present_b = pb;
        it.weight_a  = wa;
        it.weight_b  = wb;
        it.last      = last;
        return it;
    endfunction

    function automatic logic [VALUE_W-1:0] random_objective();
        case ($urandom_range(0, 6))
            0:       return $urandom();
            1:       return VALUE_TOP;
            2:       return VALUE_BOT;
            3:       return 32'($urandom_range(0, 4000)) - 32'd2000;
            4:       return {{12{1'b0}}, 20'($urandom())} - 32'h0008_0000;
            default: return 32'($urandom_range(0, 200000)) - 32'd100000;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic apply_reset();
        clear_pool_range();
        worst_a       = '0;
        worst_b       = '0;
        missing_a     = 1'b0;
        missing_b     = 1'b0;
        share_weights = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
    endtask

    // Extremes, flat slots, saturation, absence, and register sharing
    task automatic test_directed_cases();
        t_objective_item it;
        // Never-sampled slot scores nothing
        send_item(compare_element(0, 32'd5, 1, 16'hFFFF, 32'd9, 1, 16'hFFFF, 1));
        send_item(frame_sample(1, 0, VALUE_BOT, 1));
        send_item(frame_sample(0, 0, VALUE_TOP, 1));
        send_item(frame_sample(0, 1, 32'd0, 1));
        send_item(frame_sample(0, 1, 32'd1, 1));
        // Absent pool value is skipped
        send_item(frame_sample(0, 2, 32'd5, 0));
        // last is ignored on a frame sample
        it = frame_sample(0, 3, -32'sd100, 1);
        it.last = 1'b1;
        send_item(it);
        send_item(frame_sample(0, 3, 32'd100, 1));
        // Full span, value at maximum against value at minimum; new_frame ignored
        it = compare_element(0, VALUE_TOP, 1, 16'hFFFF, VALUE_BOT, 1, 16'hFFFF, 0);
        it.new_frame = 1'b1;
        send_item(it);
        // Unit span saturates; value at minimum adds nothing
        send_item(compare_element(1, VALUE_TOP, 1, 16'd1, 32'd0, 1, 16'hFFFF, 0));
        // Zero weight, and value below the minimum
        send_item(compare_element(3, 32'd0, 1, 16'd0, VALUE_BOT, 1, 16'h1000, 1));
        send_item(compare_element(3, 32'd0, 1, 16'h1000, 32'd50, 1, 16'h1000, 1));
        // Flat slot with values present
        send_item(compare_element(2, VALUE_TOP, 1, 16'hFFFF, 32'd7, 1, 16'hFFFF, 1));
        // Absent objectives, each side and both
        send_item(compare_element(3, 32'd50, 0, 16'h1000, 32'd0, 1, 16'h1000, 1));
        send_item(compare_element(3, 32'd50, 1, 16'h1000, 32'd0, 0, 16'h1000, 1));
        send_item(compare_element(0, 32'd50, 0, 16'h1000, 32'd0, 0, 16'h1000, 1));
        // Equal finite scores
        send_item(compare_element(3, 32'd60, 1, 16'h2345, 32'd60, 1, 16'h2345, 1));
        // Pool update in the middle of a comparison keeps the running scores
        send_item(compare_element(3, 32'd100, 1, 16'h1000, 32'd20, 1, 16'h1000, 0));
        send_item(frame_sample(0, 3, 32'd300, 1));
        send_item(compare_element(3, 32'd0, 1, 16'h1000, 32'd300, 1, 16'h0800, 1));
        drain_results();
        // Candidate b takes candidate a's weights
        write_share(1'b1);
        send_item(compare_element(3, 32'd0, 1, 16'h2000, 32'd200, 1, 16'd0, 1));
        send_item(compare_element(0, 32'd0, 1, 16'hFFFF, 32'd0, 1, 16'd0, 1));
        drain_results();
        write_share(1'b0);
    endtask

    // Hold the result side long enough that the block stalls its input
    task automatic test_output_backpressure();
        drain_results();
        hold_request = 1'b1;
        wait (receiver_holding);
        no_gap = 1'b1;
        for (int c = 0; c < 6; c++) begin
            send_item(compare_element(c % NSLOTS, random_objective(), 1, random_weight(),
                                      random_objective(), 1, random_weight(), 0));
            send_item(compare_element((c + 1) % NSLOTS, random_objective(), 1,
                                      random_weight(), random_objective(), 1,
                                      random_weight(), 1));
        end
        no_gap = 1'b0;
        drain_results();
    endtask

    // Well-formed pools and comparisons with random content, plus noise
    task automatic test_random_phases();
        int              phase;
        int              n;
        int              pick;
        t_objective_item it;
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
                n = $urandom_range(2, 10);
                for (int k = 0; k < n; k++) begin
                    it = frame_sample(k == 0, $urandom_range(0, NSLOTS - 1),
                                      random_objective(), $urandom_range(0, 9) != 0);
                    it.last = 1'($urandom_range(0, 1));
                    send_item(it);
                end
            end else if (pick < 16) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    it = compare_element($urandom_range(0, NSLOTS - 1),
                                         random_objective(), $urandom_range(0, 19) != 0,
                                         random_weight(), random_objective(),
                                         $urandom_range(0, 19) != 0, random_weight(),
                                         k == n - 1);
                    it.new_frame = 1'($urandom_range(0, 1));
                    send_item(it);
                end
            end else begin
                // Raw noise: every field drawn at random
                it.mode      = 1'($urandom_range(0, 1));
                it.new_frame = ($urandom_range(0, 3) == 0);
                it.slot      = SLOT_W'($urandom());
                it.value_a   = $urandom();
                it.present_a = 1'($urandom_range(0, 1));
                it.value_b   = $urandom();
                it.present_b = 1'($urandom_range(0, 1));
                it.weight_a  = 16'($urandom());
                it.weight_b  = 16'($urandom());
                it.last      = 1'($urandom_range(0, 1));
                send_item(it);
            end
            // Switch the register between phases once the block is quiet
            if (items_sent >= (phase + 1) * 190) begin
                phase++;
                drain_results();
                write_share(phase % 2 == 1);
            end
        end
    endtask

    initial begin
        apply_reset();
        test_directed_cases();
        test_output_backpressure();
        test_random_phases();
        drain_results();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ctrl.sv
hw/rtl/tsc_dp.sv
hw/rtl/tchebycheff_scalarized_compare_top.sv
hw/rtl/tsc_checker.sv
tb/tb_tchebycheff_scalarized_compare_top.sv
